// ===== rtl/assert_macros.svh =====
// assertion macros shared by the allocator rtl
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define BBA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: check failed");

// antecedent implies consequent in the next cycle
`define BBA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ===== rtl/bba_pkg.sv =====
// shared types and constants of the bitmap block allocator
// no dependencies; imported by the controller, datapath and top level
package bba_pkg;

  localparam int unsigned BLK_W       = 16;
  localparam int unsigned CNT_W       = 17;
  localparam int unsigned OP_W        = 3;
  localparam int unsigned ST_W        = 2;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned BLOCK_SPACE = 65536;

  // operation codes
  localparam logic [OP_W-1:0] OP_ALLOC  = 3'd0;
  localparam logic [OP_W-1:0] OP_FREE   = 3'd1;
  localparam logic [OP_W-1:0] OP_READ   = 3'd2;
  localparam logic [OP_W-1:0] OP_WRITE  = 3'd3;
  localparam logic [OP_W-1:0] OP_FORMAT = 3'd4;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_NOFREE = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE  = 2'd2;

  // configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_META  = 2'd1;
  localparam logic [CNT_W-1:0]     TOTAL_RESET = 17'd65536;
  localparam logic [CNT_W-1:0]     META_RESET  = 17'd0;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [BLK_W-1:0] block;
    logic             bit_value;
  } in_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [BLK_W-1:0] result_block;
    logic             read_bit;
    logic [CNT_W-1:0] free_count;
  } out_t;

  // where an accepted transaction goes next
  typedef enum logic [1:0] {
    PATH_DONE = 2'd0,
    PATH_BIT  = 2'd1,
    PATH_SCAN = 2'd2,
    PATH_FMT  = 2'd3
  } path_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic idx_step;
    logic rd_issue;
    logic bit_update;
    logic scan_step;
    logic sweep_step;
    logic sweep_result;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    path_e path;
    logic  scan_hit;
    logic  scan_miss;
    logic  sweep_last;
    logic  out_free;
  } dp_status_t;

endpackage

// ===== rtl/bba_ram.sv =====
// generic single-clock ram, one write and one registered read port
// no dependencies
module bba_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bba_ctrl.sv =====
// controller state machine of the allocator
// depends on bba_pkg for the command and status structs
module bba_ctrl import bba_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t st_i,
  output cmd_t       cmd_o
);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_IDX   = 8'b0000_0100,
    S_RD    = 8'b0000_1000,
    S_UPD   = 8'b0001_0000,
    S_SCAN  = 8'b0010_0000,
    S_FMT   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.sweep_step = 1'b1;
        if (st_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          case (st_i.path)
            PATH_BIT:  state_d = S_IDX;
            PATH_SCAN: state_d = S_SCAN;
            PATH_FMT:  state_d = S_FMT;
            default:   state_d = S_DONE;
          endcase
        end
      end
      S_IDX: begin
        cmd_o.idx_step = 1'b1;
        state_d        = S_RD;
      end
      S_RD: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = S_UPD;
      end
      S_UPD: begin
        cmd_o.bit_update = 1'b1;
        state_d          = S_DONE;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (st_i.scan_hit || st_i.scan_miss) begin
          state_d = S_DONE;
        end
      end
      S_FMT: begin
        cmd_o.sweep_step   = 1'b1;
        cmd_o.sweep_result = 1'b1;
        if (st_i.sweep_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (st_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  // state register, reset starts the map clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/bba_dpath.sv =====
// datapath of the allocator: config registers, free count, map ram,
// block index split, first-fit scan, format sweep and output register
// depends on bba_pkg and bba_ram
module bba_dpath import bba_pkg::*; #(
  parameter int unsigned MAX_BLOCKS    = 65536,
  parameter int unsigned MAP_WORD_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CNT_W-1:0]     cfg_data_i,
  input  in_t                  in_data_i,
  input  logic                 out_ready_i,
  input  cmd_t                 cmd_i,
  output dp_status_t           st_o,
  output logic                 out_valid_o,
  output out_t                 out_data_o
);

  localparam int unsigned LIMIT  = (MAX_BLOCKS < BLOCK_SPACE) ? MAX_BLOCKS : BLOCK_SPACE;
  localparam int unsigned DEPTH  = (LIMIT + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned OFF_W  = $clog2(MAP_WORD_BITS);
  localparam int unsigned RECIP  = BLOCK_SPACE / MAP_WORD_BITS;
  localparam int unsigned RCP_W  = $clog2(RECIP + 1);
  localparam int unsigned PROD_W = BLK_W + RCP_W;

  localparam logic [CNT_W-1:0]         LIMIT_C   = CNT_W'(LIMIT);
  localparam logic [CNT_W-1:0]         WORD_C    = CNT_W'(MAP_WORD_BITS);
  localparam logic [RCP_W-1:0]         RECIP_C   = RCP_W'(RECIP);
  localparam logic [AW-1:0]            LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [MAP_WORD_BITS-1:0] WORD_ONES = {MAP_WORD_BITS{1'b1}};

  typedef logic [MAP_WORD_BITS-1:0] word_t;

  // control registers
  logic [CNT_W-1:0] total_q, meta_q, free_q, free_d;
  logic             out_v_q, eval_v_q;
  logic [AW-1:0]    sweep_addr_q;
  logic [CNT_W-1:0] sweep_base_q, meff_q;

  // payload registers
  logic [OP_W-1:0]   op_q;
  logic [BLK_W-1:0]  blk_q;
  logic              val_q;
  logic [PROD_W-1:0] prod_q;
  logic [AW-1:0]     widx_q;
  logic [OFF_W-1:0]  boff_q;
  logic [AW-1:0]     iss_addr_q, eval_addr_q;
  logic [CNT_W-1:0]  iss_base_q, eval_base_q;
  out_t              res_q, out_q;

  // combinational
  logic [CNT_W-1:0]   n_c, meff_c, free_inc;
  logic [CNT_W:0]     inc_wide;
  logic               in_oor;
  path_e              path_c;
  out_t               imm_res, res_d;
  logic               res_load;
  logic [CNT_W-1:0]   q_est, rem_c, widx_c, boff_c;
  logic [2*CNT_W-1:0] qw_c;
  word_t              ram_rdata, ram_wdata, bit_mask, upd_word;
  logic               ram_we, bit_cur;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic               iss_go, any_zero, scan_hit, scan_miss;
  word_t              zeros, low;
  logic [OFF_W-1:0]   zpos;
  logic [CNT_W-1:0]   cand;
  word_t              sweep_word;
  logic [CNT_W-1:0]   meta_diff;
  logic               sweep_last, sweep_done_fmt;

  // managed block count
  assign n_c    = (total_q > LIMIT_C) ? LIMIT_C : total_q;
  assign meff_c = (meta_q > n_c) ? n_c : meta_q;
  assign in_oor = ({1'b0, in_data_i.block} >= n_c);

  // decode of the offered transaction and its immediate result
  always_comb begin
    path_c               = PATH_DONE;
    imm_res.status       = ST_OK;
    imm_res.result_block = '0;
    imm_res.read_bit     = 1'b0;
    imm_res.free_count   = free_q;
    case (in_data_i.op)
      OP_ALLOC: begin
        if (free_q == '0) begin
          imm_res.status = ST_NOFREE;
        end else begin
          path_c = PATH_SCAN;
        end
      end
      OP_FREE, OP_READ, OP_WRITE: begin
        imm_res.result_block = in_data_i.block;
        if (in_oor) begin
          imm_res.status = ST_RANGE;
        end else begin
          path_c = PATH_BIT;
        end
      end
      OP_FORMAT: begin
        path_c = PATH_FMT;
      end
      default: begin
        path_c = PATH_DONE;
      end
    endcase
  end

  // block number split into word index and bit offset (reciprocal estimate)
  always_comb begin
    q_est = CNT_W'(prod_q[PROD_W-1:BLK_W]);
    qw_c  = (2*CNT_W)'(q_est) * (2*CNT_W)'(WORD_C);
    rem_c = {1'b0, blk_q} - qw_c[CNT_W-1:0];
    if (rem_c >= WORD_C) begin
      widx_c = q_est + 1'b1;
      boff_c = rem_c - WORD_C;
    end else begin
      widx_c = q_est;
      boff_c = rem_c;
    end
  end

  // single bit update for free, read and write
  assign bit_mask = word_t'(1) << boff_q;
  assign bit_cur  = ram_rdata[boff_q];
  assign inc_wide = {1'b0, free_q} + 1'b1;
  assign free_inc = (inc_wide > {1'b0, n_c}) ? n_c : inc_wide[CNT_W-1:0];

  always_comb begin
    upd_word = ram_rdata;
    case (op_q)
      OP_FREE:  upd_word = ram_rdata & ~bit_mask;
      OP_WRITE: upd_word = val_q ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);
      default:  upd_word = ram_rdata;
    endcase
  end

  // first-fit scan: issue one word a cycle, evaluate the word read last cycle
  assign iss_go   = cmd_i.scan_step && (iss_base_q < n_c);
  assign zeros    = ~ram_rdata;
  assign low      = zeros & (~zeros + 1'b1);
  assign any_zero = |zeros;

  always_comb begin
    zpos = '0;
    for (int i = 0; i < MAP_WORD_BITS; i++) begin
      if (low[i]) begin
        zpos = zpos | OFF_W'(i);
      end
    end
  end

  assign cand      = eval_base_q + CNT_W'(zpos);
  assign scan_hit  = cmd_i.scan_step && eval_v_q && any_zero && (cand < n_c);
  assign scan_miss = cmd_i.scan_step &&
                     ((eval_v_q && any_zero && (cand >= n_c)) || (!eval_v_q && !iss_go));

  // format and reset sweep word: leading meff_q blocks used, rest free
  assign meta_diff = meff_q - sweep_base_q;

  always_comb begin
    if (meff_q <= sweep_base_q) begin
      sweep_word = '0;
    end else if (meta_diff >= WORD_C) begin
      sweep_word = WORD_ONES;
    end else begin
      sweep_word = ~(WORD_ONES << meta_diff[OFF_W-1:0]);
    end
  end

  assign sweep_last     = (sweep_addr_q == LAST_ADDR);
  assign sweep_done_fmt = cmd_i.sweep_step && cmd_i.sweep_result && sweep_last;

  // ram port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sweep_addr_q;
    ram_wdata = sweep_word;
    ram_raddr = cmd_i.rd_issue ? widx_q : iss_addr_q;
    if (cmd_i.sweep_step) begin
      ram_we = 1'b1;
    end else if (scan_hit) begin
      ram_we    = 1'b1;
      ram_waddr = eval_addr_q;
      ram_wdata = ram_rdata | low;
    end else if (cmd_i.bit_update && (op_q != OP_READ)) begin
      ram_we    = 1'b1;
      ram_waddr = widx_q;
      ram_wdata = upd_word;
    end
  end

  bba_ram #(
    .WIDTH (MAP_WORD_BITS),
    .DEPTH (DEPTH)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // free count and pending result
  always_comb begin
    free_d = free_q;
    if (scan_hit) begin
      free_d = free_q - 1'b1;
    end else if (cmd_i.bit_update && (op_q == OP_FREE)) begin
      free_d = free_inc;
    end else if (sweep_done_fmt) begin
      free_d = n_c - meff_q;
    end
  end

  always_comb begin
    res_load            = 1'b0;
    res_d.status        = ST_OK;
    res_d.result_block  = '0;
    res_d.read_bit      = 1'b0;
    res_d.free_count    = free_d;
    if (cmd_i.capture && (path_c == PATH_DONE)) begin
      res_load = 1'b1;
      res_d    = imm_res;
    end else if (cmd_i.bit_update) begin
      res_load           = 1'b1;
      res_d.result_block = blk_q;
      res_d.read_bit     = (op_q == OP_READ) ? bit_cur : 1'b0;
    end else if (scan_hit) begin
      res_load           = 1'b1;
      res_d.result_block = cand[BLK_W-1:0];
    end else if (scan_miss) begin
      res_load     = 1'b1;
      res_d.status = ST_NOFREE;
    end else if (sweep_done_fmt) begin
      res_load = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q      <= TOTAL_RESET;
      meta_q       <= META_RESET;
      free_q       <= LIMIT_C;
      out_v_q      <= 1'b0;
      eval_v_q     <= 1'b0;
      sweep_addr_q <= '0;
      sweep_base_q <= '0;
      meff_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_TOTAL: total_q <= cfg_data_i;
          CFG_META:  meta_q  <= cfg_data_i;
          default:   ;
        endcase
      end
      free_q <= free_d;
      if (cmd_i.out_load) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
      if (cmd_i.capture) begin
        eval_v_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        eval_v_q <= iss_go;
      end
      if (cmd_i.capture && (path_c == PATH_FMT)) begin
        sweep_addr_q <= '0;
        sweep_base_q <= '0;
        meff_q       <= meff_c;
      end else if (cmd_i.sweep_step) begin
        if (sweep_last) begin
          sweep_addr_q <= '0;
          sweep_base_q <= '0;
        end else begin
          sweep_addr_q <= sweep_addr_q + 1'b1;
          sweep_base_q <= sweep_base_q + WORD_C;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q       <= in_data_i.op;
      blk_q      <= in_data_i.block;
      val_q      <= in_data_i.bit_value;
      prod_q     <= PROD_W'(in_data_i.block) * PROD_W'(RECIP_C);
      iss_addr_q <= '0;
      iss_base_q <= '0;
    end else if (iss_go) begin
      iss_addr_q <= iss_addr_q + 1'b1;
      iss_base_q <= iss_base_q + WORD_C;
    end
    if (cmd_i.scan_step) begin
      eval_addr_q <= iss_addr_q;
      eval_base_q <= iss_base_q;
    end
    if (cmd_i.idx_step) begin
      widx_q <= widx_c[AW-1:0];
      boff_q <= boff_c[OFF_W-1:0];
    end
    if (res_load) begin
      res_q <= res_d;
    end
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  assign st_o.path       = path_c;
  assign st_o.scan_hit   = scan_hit;
  assign st_o.scan_miss  = scan_miss;
  assign st_o.sweep_last = sweep_last;
  assign st_o.out_free   = !out_v_q || out_ready_i;

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/bitmap_block_allocator.sv =====
// top level of the bitmap block allocator, first fit
// depends on bba_pkg, bba_ctrl, bba_dpath (with bba_ram) and assert_macros.svh
//
//   channel  signals                              direction
//   in       in_valid_i in_ready_o in_data_i      transaction in: op, block, bit_value
//   out      out_valid_o out_ready_i out_data_o   transaction out: status, block, bit, count
//   cfg      cfg_valid_i cfg_ready_o cfg_index_i  register write, always ready
//            cfg_data_i
//
// free, read and write step through index split, ram read, update and output.
// allocate scans the map from word 0, one map word per cycle from the ram read port,
// until it finds a clear bit below the managed count or runs out of words;
// it goes straight to output when the free count is zero, as do out of range and unknown transactions.
// format writes each of the MAX_BLOCKS/MAP_WORD_BITS map words once (2048 words by default).
// after reset a clearing pass writes every map word, in_ready_o low.
// a finished result waits in the output register; the next transaction is accepted meanwhile.
module bitmap_block_allocator import bba_pkg::*; #(
  parameter int unsigned MAX_BLOCKS    = 65536,
  parameter int unsigned MAP_WORD_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_t                  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_t                 out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CNT_W-1:0]     cfg_data_i
);

  `include "assert_macros.svh"

  localparam int unsigned      LIMIT   = (MAX_BLOCKS < BLOCK_SPACE) ? MAX_BLOCKS : BLOCK_SPACE;
  localparam logic [CNT_W-1:0] LIMIT_C = CNT_W'(LIMIT);

  cmd_t       cmd;
  dp_status_t st;

  // configuration writes are taken every cycle
  assign cfg_ready_o = 1'b1;

  bba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  bba_dpath #(
    .MAX_BLOCKS    (MAX_BLOCKS),
    .MAP_WORD_BITS (MAP_WORD_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // one transaction at a time inside the block
  `BBA_ASSERT_NXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)

  // a waiting result is never overwritten
  `BBA_ASSERT_IMP(a_no_overwrite, cmd.out_load, !out_valid_o || out_ready_i)

  // failed allocation carries no block and no bit
  `BBA_ASSERT_IMP(a_nofree_clean, out_valid_o && (out_data_o.status == ST_NOFREE),
                  (out_data_o.result_block == '0) && !out_data_o.read_bit)

  // free count never exceeds the block space the map can hold
  `BBA_ASSERT_IMP(a_count_bound, out_valid_o, out_data_o.free_count <= LIMIT_C)

endmodule

// ===== bench/testbench.sv =====
// self-checking testbench for bitmap_block_allocator
// depends on bba_pkg and the allocator rtl; keeps a shadow copy of the map and count
// and checks every result transaction against it in order
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bba_pkg::*;

  localparam int unsigned WORD_BITS   = 32;
  localparam int unsigned MAP_WORDS   = 65536 / WORD_BITS;
  localparam int unsigned BLOCK_LIMIT = 65536;
  localparam int unsigned STALL_LIMIT = 20000;

  // op codes the block leaves undefined
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

  // shadow of the occupancy map, free count and registers, plus awaited replies
  class allocator_shadow;
    logic [WORD_BITS-1:0] occ_map [MAP_WORDS];
    logic [CNT_W-1:0]     free_cnt;
    logic [CNT_W-1:0]     total_reg;
    logic [CNT_W-1:0]     meta_reg;
    out_t                 awaited_replies [$];
    int                   errors;

    function new();
      foreach (occ_map[w]) occ_map[w] = '0;
      total_reg = TOTAL_RESET;
      meta_reg  = META_RESET;
      free_cnt  = 17'd65536;
      errors    = 0;
    endfunction

    function int unsigned managed_count();
      return (total_reg > BLOCK_LIMIT) ? BLOCK_LIMIT : int'(total_reg);
    endfunction

    function void apply_config(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] val);
      if (idx == CFG_TOTAL) total_reg = val;
      else if (idx == CFG_META) meta_reg = val;
    endfunction

    // work out the reply of an accepted request and update the shadow
    function void apply_request(in_t req);
      int unsigned n;
      int unsigned m;
      int unsigned c;
      int unsigned w;
      int unsigned s;
      bit          found;
      out_t        rsp;
      n     = managed_count();
      rsp   = '0;
      found = 1'b0;
      case (req.op)
        OP_ALLOC: begin
          // first fit: lowest clear bit below the managed count
          if (free_cnt != 0) begin
            for (w = 0; w < MAP_WORDS; w++) begin
              if (w * WORD_BITS >= n) break;
              if (occ_map[w] != '1) begin
                s = 0;
                while (occ_map[w][s]) s++;
                if (w * WORD_BITS + s < n) begin
                  rsp.result_block = BLK_W'(w * WORD_BITS + s);
                  found = 1'b1;
                end
                break;
              end
            end
          end
          if (found) begin
            occ_map[rsp.result_block / WORD_BITS][rsp.result_block % WORD_BITS] = 1'b1;
            free_cnt = free_cnt - 1'b1;
          end else begin
            rsp.status = ST_NOFREE;
          end
        end
        OP_FREE, OP_READ, OP_WRITE: begin
          rsp.result_block = req.block;
          if (req.block >= n) begin
            rsp.status = ST_RANGE;
          end else if (req.op == OP_FREE) begin
            occ_map[req.block / WORD_BITS][req.block % WORD_BITS] = 1'b0;
            c = free_cnt + 1;
            if (c > n) c = n;
            free_cnt = CNT_W'(c);
          end else if (req.op == OP_READ) begin
            rsp.read_bit = occ_map[req.block / WORD_BITS][req.block % WORD_BITS];
          end else begin
            occ_map[req.block / WORD_BITS][req.block % WORD_BITS] = req.bit_value;
          end
        end
        OP_FORMAT: begin
          // clear the map, then mark the leading metadata blocks used
          m = meta_reg;
          if (m > n) m = n;
          for (w = 0; w < MAP_WORDS; w++) begin
            if ((w + 1) * WORD_BITS <= m) occ_map[w] = '1;
            else if (w * WORD_BITS < m) occ_map[w] = (32'h1 << (m - w * WORD_BITS)) - 1;
            else occ_map[w] = '0;
          end
          free_cnt = CNT_W'(n - m);
        end
        default: ;
      endcase
      rsp.free_count = free_cnt;
      awaited_replies.push_back(rsp);
    endfunction

    // compare a reply transaction against the oldest awaited one
    function void compare_response(out_t got);
      out_t want;
      if (awaited_replies.size() == 0) begin
        $display("%0t: unexpected result transaction %h", $time, got);
        errors++;
        return;
      end
      want = awaited_replies.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.result_block !== want.result_block) begin
        $display("%0t: result_block expected %0d actual %0d", $time,
                 want.result_block, got.result_block);
        errors++;
      end
      if (got.read_bit !== want.read_bit) begin
        $display("%0t: read_bit expected %0d actual %0d", $time, want.read_bit, got.read_bit);
        errors++;
      end
      if (got.free_count !== want.free_count) begin
        $display("%0t: free_count expected %0d actual %0d", $time,
                 want.free_count, got.free_count);
        errors++;
      end
    endfunction

    function bit busy();
      return awaited_replies.size() != 0;
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  in_t                  in_data_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  out_t                 out_data_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CNT_W-1:0]     cfg_data_i;

  allocator_shadow shadow;
  bit              idle_on;
  int unsigned     stall_cycles = 0;

  bitmap_block_allocator DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // clock
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // receiver: random stall bursts while idling is enabled
  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // result checking
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) shadow.compare_response(out_data_o);
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("bitmap_block_allocator verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic in_t make_req(logic [OP_W-1:0] op, logic [BLK_W-1:0] blk, logic bv);
    in_t req;
    req.op        = op;
    req.block     = blk;
    req.bit_value = bv;
    return req;
  endfunction

  // random request: often near the allocated region, sometimes anywhere
  function automatic in_t random_req(int unsigned n);
    int unsigned pick;
    int unsigned upper;
    in_t         req;
    pick          = $urandom_range(0, 99);
    upper         = (n > 65535) ? 65535 : n;
    req.bit_value = 1'($urandom_range(0, 1));
    if (pick < 38) req.op = OP_ALLOC;
    else if (pick < 62) req.op = OP_FREE;
    else if (pick < 76) req.op = OP_READ;
    else if (pick < 90) req.op = OP_WRITE;
    else if (pick < 92) req.op = OP_FORMAT;
    else if (pick < 94) req.op = OP_SPARE_A;
    else if (pick < 96) req.op = OP_SPARE_B;
    else if (pick < 98) req.op = OP_SPARE_C;
    else req.op = OP_READ;
    if ($urandom_range(0, 9) == 0) req.block = BLK_W'($urandom());
    else if ($urandom_range(0, 1) == 0)
      req.block = BLK_W'($urandom_range(0, (upper > 63) ? 63 : upper));
    else req.block = BLK_W'($urandom_range(0, upper));
    return req;
  endfunction

  // send one request transaction, with an optional gap before it
  task automatic send_req(input in_t req);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    shadow.apply_request(req);
  endtask

  // hold off the sender until every awaited reply has come back
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (shadow.busy()) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // write both registers back to back; valid stays high between them
  task automatic write_config(input logic [CNT_W-1:0] total, input logic [CNT_W-1:0] meta);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_TOTAL;
    cfg_data_i  <= total;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    shadow.apply_config(CFG_TOTAL, total);
    cfg_index_i <= CFG_META;
    cfg_data_i  <= meta;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    shadow.apply_config(CFG_META, meta);
    cfg_valid_i <= 1'b0;
  endtask

  // one random phase under a given register setting
  task automatic run_phase(input logic [CNT_W-1:0] total, input logic [CNT_W-1:0] meta,
                           input int unsigned count, input bit with_format, input bit idle);
    wait_quiet();
    write_config(total, meta);
    idle_on = idle;
    if (with_format) begin
      send_req(make_req(OP_FORMAT, BLK_W'($urandom()), 1'($urandom_range(0, 1))));
    end
    repeat (count) send_req(random_req(shadow.managed_count()));
  endtask

  initial begin
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CFG_TOTAL;
    cfg_data_i  <= '0;
    rst_ni      <= 1'b0;
    idle_on = 1'b1;
    shadow  = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset defaults: first fit, reads at both ends, free then realloc, undefined ops
    send_req(make_req(OP_ALLOC, 16'd0, 1'b0));
    send_req(make_req(OP_ALLOC, 16'hFFFF, 1'b1));
    send_req(make_req(OP_READ, 16'd0, 1'b0));
    send_req(make_req(OP_READ, 16'hFFFF, 1'b0));
    send_req(make_req(OP_WRITE, 16'hFFFF, 1'b1));
    send_req(make_req(OP_READ, 16'hFFFF, 1'b0));
    send_req(make_req(OP_FREE, 16'd1, 1'b0));
    send_req(make_req(OP_ALLOC, 16'd0, 1'b0));
    send_req(make_req(OP_SPARE_A, 16'hFFFF, 1'b1));
    send_req(make_req(OP_SPARE_C, 16'd0, 1'b0));

    // shrink the map: count above the new total is lowered on free,
    // then run the count down to empty and make the map full with a nonzero count
    wait_quiet();
    write_config(17'd8, 17'd3);
    send_req(make_req(OP_FREE, 16'd2, 1'b0));
    send_req(make_req(OP_FORMAT, 16'd0, 1'b0));
    repeat (6) send_req(make_req(OP_ALLOC, 16'd0, 1'b0));
    send_req(make_req(OP_FREE, 16'd7, 1'b0));
    send_req(make_req(OP_WRITE, 16'd7, 1'b1));
    send_req(make_req(OP_ALLOC, 16'd0, 1'b0));
    send_req(make_req(OP_READ, 16'd8, 1'b0));
    send_req(make_req(OP_FREE, 16'hFFFF, 1'b0));
    send_req(make_req(OP_WRITE, 16'd100, 1'b1));
    send_req(make_req(OP_SPARE_B, 16'd5, 1'b1));

    // metadata larger than the map, then free of a free block up to saturation
    wait_quiet();
    write_config(17'd8, 17'd65536);
    send_req(make_req(OP_FORMAT, 16'd0, 1'b0));
    send_req(make_req(OP_ALLOC, 16'd0, 1'b0));
    wait_quiet();
    write_config(17'd2, 17'd0);
    send_req(make_req(OP_FORMAT, 16'd0, 1'b0));
    send_req(make_req(OP_FREE, 16'd1, 1'b0));

    // random phases across settings, extremes included
    run_phase(17'd16, 17'd2, 150, 1'b1, 1'b1);
    run_phase(17'd1, 17'd0, 80, 1'b1, 1'b0);
    run_phase(17'd33, 17'd32, 110, 1'b1, 1'b1);
    run_phase(17'd65536, 17'd0, 150, 1'b0, 1'b1);
    run_phase(17'd0, 17'd0, 40, 1'b0, 1'b1);
    run_phase(17'd131071, 17'd131071, 80, 1'b1, 1'b1);
    run_phase(17'd40, 17'd65536, 60, 1'b1, 1'b0);
    run_phase(CNT_W'($urandom_range(1, 200)), CNT_W'($urandom_range(0, 20)), 120, 1'b1, 1'b1);
    run_phase(17'd100, 17'd5, 100, 1'b0, 1'b1);
    // last part runs without idling on either side
    run_phase(17'd24, 17'd3, 130, 1'b1, 1'b0);

    // drain, then give stray results a chance to show up
    wait_quiet();
    repeat (40) @(posedge clk_i);
    if (shadow.errors == 0 && !shadow.busy()) begin
      $display("bitmap_block_allocator verification clean");
    end else begin
      $display("bitmap_block_allocator verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/bba_pkg.sv
rtl/bba_ram.sv
rtl/bba_ctrl.sv
rtl/bba_dpath.sv
rtl/bitmap_block_allocator.sv
bench/testbench.sv
